// File: sv/rsst_pkg.sv
`default_nettype none

package rsst_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DRAW_W   = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SIZE_W   = 7;

  localparam int unsigned IN_FIELDS_W  = OP_W + VALUE_W + DRAW_W;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + VALUE_W + SIZE_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic              start;
    logic [DRAW_W-1:0] dividend;
  } div_req_t;

endpackage

`default_nettype wire

// File: sv/rsst_modulo.sv
`default_nettype none

module rsst_modulo #(
  parameter int unsigned CAPACITY = rsst_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rsst_pkg::div_req_t                req_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]     divisor_i,
  output logic                                   done_o,
  output logic [$clog2(CAPACITY)-1:0]            rem_o
);

  import rsst_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CNTW = $clog2(DRAW_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [CW-1:0]     dvs_q, dvs_d;
  logic [DRAW_W-1:0] dvd_q, dvd_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [CW:0]       trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    trial  = {rem_q, dvd_q[DRAW_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = divisor_i;
      dvd_d  = req_i.dividend;
      cnt_d  = CNTW'(DRAW_W - 1);
    end else if (busy_q) begin
      // restoring step, one dividend bit a cycle
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CW-1:0];
      end
      dvd_d = {dvd_q[DRAW_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[AW-1:0];

endmodule

`default_nettype wire

// File: sv/random_sample_set_table_unit.sv
// channel   dir  handshake                   tdata fields, lowest bit first
// s_axis    in   s_axis_tvalid/tready        op[1:0] value[33:2] random_draw[64:34]
// m_axis    out  m_axis_tvalid/tready        status[1:0] sampled_value[33:2] set_size[40:34]
//
// insert and remove are set by the linear search, which reads one store entry a cycle from
// the value memory (one write port, one read port) and stops early on a hit
// sample waits on the bit-serial modulo of the 31-bit draw; an empty sample or an unused
// opcode skips the search and the modulo
// one transaction is worked on at a time; s_axis_tready is high only when idle
// a finished result sits in the output register, so the next transaction runs while it waits
// reset clears the count, the state and the output valid; store entries hold nothing defined until written

`default_nettype none

module random_sample_set_table_unit #(
  parameter int unsigned CAPACITY = rsst_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // op, value, random_draw, zero pad
  input  wire logic [rsst_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // status, sampled_value, set_size, zero pad
  output logic [rsst_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i
);

  import rsst_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_MOVE   = 6'b000100,
    S_DIV    = 6'b001000,
    S_SAMPLE = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic                   rvld_q, rvld_d;
  op_e                    op_q, op_d;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic [AW-1:0]          slot_q, slot_d;
  status_e                res_status_q, res_status_d;
  logic [VALUE_W-1:0]     res_sample_q, res_sample_d;
  logic                   m_tvalid_q, m_tvalid_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;

  logic [VALUE_W-1:0]     mem [CAPACITY];
  logic [VALUE_W-1:0]     rdata_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_W-1:0]     mem_wdata;
  logic [AW-1:0]          mem_raddr;

  div_req_t               div_req;
  logic                   div_done;
  logic [AW-1:0]          div_rem;

  rsst_modulo #(
    .CAPACITY (CAPACITY)
  ) u_modulo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (count_q),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    idx_d            = idx_q;
    rvld_d           = 1'b0;
    op_d             = op_q;
    value_d          = value_q;
    slot_d           = slot_q;
    res_status_d     = res_status_q;
    res_sample_d     = res_sample_q;
    m_tvalid_d       = m_tvalid_q;
    m_tdata_d        = m_tdata_q;
    mem_we           = 1'b0;
    mem_waddr        = slot_q;
    mem_wdata        = value_q;
    mem_raddr        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = s_axis_tdata_i[OP_W+VALUE_W +: DRAW_W];

    if (m_tvalid_q && m_axis_tready_i) begin
      m_tvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d         = op_e'(s_axis_tdata_i[OP_W-1:0]);
          value_d      = s_axis_tdata_i[OP_W +: VALUE_W];
          res_sample_d = '0;
          idx_d        = '0;
          case (s_axis_tdata_i[OP_W-1:0])
            OP_INSERT, OP_REMOVE: begin
              state_d = S_SEARCH;
            end
            OP_SAMPLE: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                div_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
            default: begin
              res_status_d = ST_MISS;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rvld_q && (rdata_q == value_q)) begin
          if (op_q == OP_INSERT) begin
            res_status_d = ST_MISS;
            state_d      = S_DONE;
          end else begin
            slot_d    = AW'(idx_q - CW'(1));
            mem_raddr = AW'(count_q - CW'(1));
            state_d   = S_MOVE;
          end
        end else if (idx_q < count_q) begin
          mem_raddr = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
          rvld_d    = 1'b1;
        end else begin
          if (op_q != OP_INSERT) begin
            res_status_d = ST_MISS;
          end else if (count_q == CW'(CAPACITY)) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = count_q[AW-1:0];
            mem_wdata    = value_q;
            count_d      = count_q + CW'(1);
            res_status_d = ST_OK;
          end
          state_d = S_DONE;
        end
      end
      S_MOVE: begin
        // last element fills the hole
        mem_we       = 1'b1;
        mem_waddr    = slot_q;
        mem_wdata    = rdata_q;
        count_d      = count_q - CW'(1);
        res_status_d = ST_OK;
        state_d      = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          mem_raddr = div_rem;
          state_d   = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        res_sample_d = rdata_q;
        res_status_d = ST_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready_i) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = OUT_TDATA_W'({SIZE_W'(count_q), res_sample_q, res_status_q});
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      rvld_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      rvld_q     <= rvld_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_sample_q <= res_sample_d;
    m_tdata_q    <= m_tdata_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule

`default_nettype wire

// File: sv/rsst_checker.sv
`default_nettype none

module rsst_checker #(
  parameter int unsigned CAPACITY = rsst_pkg::CAPACITY_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic [rsst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i
);

  import rsst_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (CAPACITY > 127) || (m_axis_tdata_o[40:34] <= CAPACITY))
    else $error("set size beyond capacity");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] == ST_EMPTY)
      |-> (m_axis_tdata_o[40:34] == '0) && (m_axis_tdata_o[33:2] == '0))
    else $error("empty status with nonzero size or sample");

  a_sample_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != ST_OK) |-> (m_axis_tdata_o[33:2] == '0))
    else $error("sample value on failed transaction");

endmodule

bind random_sample_set_table_unit rsst_checker #(
  .CAPACITY (CAPACITY)
) u_rsst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire

// File: tb/sv/random_sample_set_table_unit_test.sv
`timescale 1ns / 100ps

module random_sample_set_table_unit_test;
  import rsst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS = 680;
  localparam int unsigned POOL_SIZE = 96;

  typedef struct {
    status_e             status;
    logic [VALUE_W-1:0]  sampled;
    logic [SIZE_W-1:0]   size;
  } set_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  // op, value, random_draw, zero pad
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  // status, sampled_value, set_size, zero pad
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;

  logic [VALUE_W-1:0] set_members [CAPACITY_DEF];
  int unsigned        member_count = 0;
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];
  set_result_t        expected_q [$];
  set_result_t        head_result;
  int unsigned        error_count = 0;
  int unsigned        idle_cycles = 0;
  bit                 quiet_mode = 1'b0;

  random_sample_set_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int member_slot(logic [VALUE_W-1:0] v);
    for (int i = 0; i < int'(member_count); i++) begin
      if (set_members[i] == v) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic set_result_t apply_set_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v,
                                               logic [DRAW_W-1:0] draw);
    set_result_t r;
    int          slot;
    r.status = ST_MISS;
    r.sampled = '0;
    slot = member_slot(v);
    case (op)
      OP_INSERT: begin
        if (slot >= 0) begin
          r.status = ST_MISS;
        end else if (member_count >= CAPACITY_DEF) begin
          r.status = ST_FULL;
        end else begin
          set_members[member_count] = v;
          member_count++;
          r.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          set_members[slot] = set_members[member_count - 1];
          member_count--;
          r.status = ST_OK;
        end
      end
      OP_SAMPLE: begin
        if (member_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.sampled = set_members[int'(draw % member_count)];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.size = member_count[SIZE_W-1:0];
    return r;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
                           input logic [DRAW_W-1:0] draw);
    int unsigned gap;
    gap = pick_pause();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i <= {draw, v, op};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_q.insert(expected_q.size(), apply_set_op(op, v, draw));
  endtask

  function automatic logic [VALUE_W-1:0] absent_value();
    logic [VALUE_W-1:0] v;
    v = $urandom();
    while (member_slot(v) >= 0) v = $urandom();
    return v;
  endfunction

  function automatic logic [DRAW_W-1:0] random_draw();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 200));
      1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 200));
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic test_empty_set();
    send_item(OP_SAMPLE, 32'h0000_0000, 31'h0000_0000);
    send_item(OP_SAMPLE, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_REMOVE, 32'h0000_0000, 31'h0000_0000);
    send_item(OP_UNUSED, 32'h0000_0000, 31'h0000_0000);
  endtask

  task automatic test_extreme_values();
    send_item(OP_INSERT, 32'h8000_0000, 31'h0000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000, 31'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0001, 31'h0000_0000);
    // duplicate insert
    send_item(OP_INSERT, 32'h7FFF_FFFF, 31'h0000_0000);
    send_item(OP_SAMPLE, 32'h0000_0000, 31'h0000_0000);
    send_item(OP_SAMPLE, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_SAMPLE, 32'h0000_0000, 31'h0000_0004);
    // first slot refilled from the last one
    send_item(OP_REMOVE, 32'h8000_0000, 31'h0000_0000);
    send_item(OP_REMOVE, 32'h1234_5678, 31'h0000_0000);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_item(OP_SAMPLE, 32'h0000_0000, 31'h0000_0000);
    send_item(OP_REMOVE, 32'h0000_0001, 31'h0000_0000);
    send_item(OP_REMOVE, 32'h0000_0000, 31'h7FFF_FFFF);
    send_item(OP_REMOVE, 32'hFFFF_FFFF, 31'h0000_0000);
    send_item(OP_REMOVE, 32'h7FFF_FFFF, 31'h0000_0000);
    send_item(OP_REMOVE, 32'h7FFF_FFFF, 31'h0000_0000);
    send_item(OP_SAMPLE, 32'h0000_0000, 31'h0000_0005);
  endtask

  task automatic test_full_store();
    logic [VALUE_W-1:0] v;
    while (member_count < CAPACITY_DEF) begin
      send_item(OP_INSERT, absent_value(), random_draw());
    end
    send_item(OP_INSERT, absent_value(), random_draw());
    send_item(OP_INSERT, set_members[$urandom_range(0, CAPACITY_DEF - 1)], random_draw());
    send_item(OP_SAMPLE, $urandom(), 31'd0);
    send_item(OP_SAMPLE, $urandom(), 31'(CAPACITY_DEF - 1));
    send_item(OP_SAMPLE, $urandom(), 31'(CAPACITY_DEF));
    send_item(OP_SAMPLE, $urandom(), 31'h7FFF_FFFF);
    v = set_members[CAPACITY_DEF - 1];
    send_item(OP_REMOVE, v, random_draw());
    send_item(OP_INSERT, v, random_draw());
    send_item(OP_INSERT, absent_value(), random_draw());
    while (member_count > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(OP_SAMPLE, $urandom(), random_draw());
      end
      send_item(OP_REMOVE, set_members[$urandom_range(0, member_count - 1)], random_draw());
    end
  endtask

  task automatic random_item(input int unsigned mode);
    int unsigned        r;
    int unsigned        insert_w;
    int unsigned        remove_w;
    logic [VALUE_W-1:0] v;
    insert_w = (mode == 0) ? 65 : (mode == 1) ? 15 : 35;
    remove_w = (mode == 0) ? 15 : (mode == 1) ? 65 : 35;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_item(OP_UNUSED, $urandom(), 31'($urandom()));
    end else if (r < 2 + insert_w) begin
      v = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : $urandom();
      send_item(OP_INSERT, v, random_draw());
    end else if (r < 2 + insert_w + remove_w) begin
      r = $urandom_range(0, 99);
      if (r < 65 && member_count > 0) begin
        v = set_members[$urandom_range(0, member_count - 1)];
      end else if (r < 90) begin
        v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        v = $urandom();
      end
      send_item(OP_REMOVE, v, random_draw());
    end else begin
      send_item(OP_SAMPLE, $urandom(), random_draw());
    end
  endtask

  // fill, drain and balanced stretches so the set swings between empty and full
  task automatic test_random_mix();
    int unsigned sent;
    int unsigned mode;
    int unsigned stretch;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      stretch = $urandom_range(40, 100);
      quiet_mode = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < int'(stretch) && sent < RANDOM_ITEMS; j++) begin
        random_item(mode);
        sent++;
      end
    end
    quiet_mode = 1'b0;
  endtask

  function automatic void compare_field(string field, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, m_axis_tdata_o);
        error_count++;
      end else begin
        head_result = expected_q.pop_front();
        compare_field("status", VALUE_W'(head_result.status),
                      VALUE_W'(m_axis_tdata_o[0 +: STATUS_W]));
        compare_field("sampled_value", head_result.sampled, m_axis_tdata_o[STATUS_W +: VALUE_W]);
        compare_field("set_size", VALUE_W'(head_result.size),
                      VALUE_W'(m_axis_tdata_o[STATUS_W + VALUE_W +: SIZE_W]));
      end
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          hold = pick_pause();
        end
      end
    end
  end

  // no transaction on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("random_sample_set_table_unit test failed");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      value_pool[i] = $urandom();
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_set();
    test_extreme_values();
    test_full_store();
    test_random_mix();

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("random_sample_set_table_unit test passed");
    end else begin
      $display("random_sample_set_table_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rsst_pkg.sv
sv/rsst_modulo.sv
sv/random_sample_set_table_unit.sv
sv/rsst_checker.sv
tb/sv/random_sample_set_table_unit_test.sv
